// ===== design/bffa_pkg.sv =====
package bffa_pkg;

    // Field widths of the request and result beats
    localparam int NUM_W      = 14;
    localparam int STAT_W     = 2;
    localparam int CNT_W      = 15;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - CNT_W - STAT_W - NUM_W;

    // Bitmap organisation: one memory word holds 64 entries
    localparam int WORD_W    = 64;
    localparam int BIT_POS_W = 6;

    localparam int MAX_ENTRIES_DEF = 8192;

    localparam logic [NUM_W-1:0] LIMIT_RESET = 14'd8192;

    localparam logic signed [CNT_W-1:0] CNT_MAX = 15'sd8192;
    localparam logic signed [CNT_W-1:0] CNT_MIN = -15'sd8192;
    localparam logic signed [CNT_W-1:0] CNT_ONE = 15'sd1;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_MOD,
        S_RESP
    } state_t;

    // Result of the first-clear-bit search over one word
    typedef struct packed {
        logic                 found;
        logic [BIT_POS_W-1:0] pos;
    } hit_t;

endpackage

// ===== design/bffa_bitmap_mem.sv =====
module bffa_bitmap_mem #(
    parameter int WORDS = 128,
    parameter int AW    = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [bffa_pkg::WORD_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [bffa_pkg::WORD_W-1:0] wr_data
);
    import bffa_pkg::*;

    logic [WORD_W-1:0] mem_array [WORDS];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic [WORDS-1:0]  row_valid_reg;
    logic [WORDS-1:0]  row_valid_next;

    // Storage: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    // Mark a row written; an unwritten row reads as all free
    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== design/bffa_first_zero.sv =====
module bffa_first_zero #(
    parameter int AW = 7
) (
    input  logic [bffa_pkg::WORD_W-1:0] word_data,
    input  logic [AW-1:0]               word_idx,
    input  logic [bffa_pkg::NUM_W-1:0]  limit,
    output bffa_pkg::hit_t              hit
);
    import bffa_pkg::*;

    logic [NUM_W-1:0]     full_words;
    logic [BIT_POS_W-1:0] rem_bits;
    logic [WORD_W-1:0]    in_limit;
    logic [WORD_W-1:0]    avail;

    // Keep only the bits of this word that lie below the limit
    always_comb
    begin
        full_words = limit >> BIT_POS_W;
        rem_bits   = limit[BIT_POS_W-1:0];
        if (32'(word_idx) < 32'(full_words))
        begin
            in_limit = '1;
        end
        else if (32'(word_idx) == 32'(full_words))
        begin
            in_limit = (WORD_W'(1) << rem_bits) - WORD_W'(1);
        end
        else
        begin
            in_limit = '0;
        end
        avail = ~word_data & in_limit;
    end

    // Priority-encode the lowest free bit
    always_comb
    begin
        hit.found = |avail;
        hit.pos   = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                hit.pos = BIT_POS_W'(i);
            end
        end
    end

endmodule

// ===== design/bitmap_first_free_allocator_core.sv =====
// Free: the addressed word is read, cleared in S_FREE_MOD and written back, and the result
// beat is registered from S_RESP; a new request is taken only once that beat is loaded.
// Allocate: one bitmap word (64 entries) examined per cycle by the search unit, up to
// ceil(limit/64) words (128 at 8192 entries); a new request waits for the result beat.
// Reset (rst_n, async, low): bitmap all free at once through per-row valid bits,
// counter zero, entries_in_use 8192; no clearing pass.
module bitmap_first_free_allocator_core #(
    parameter int MAX_ENTRIES = bffa_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bffa_pkg::IN_DATA_W-1:0]  s_tdata,   // [13:0] entry_number, [15:14] zero
    input  logic                            s_tuser,   // [0] command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bffa_pkg::OUT_DATA_W-1:0] m_tdata,   // [13:0] allocated_number,
                                                       // [15:14] status,
                                                       // [30:16] free_count, [31] zero
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bffa_pkg::NUM_W-1:0]      cfg_data   // entries_in_use
);
    import bffa_pkg::*;

    localparam int WORDS = (MAX_ENTRIES + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            word_reg, word_next;
    logic [AW-1:0]            last_word_reg, last_word_next;
    logic [NUM_W-1:0]         limit_reg, limit_next;
    logic [BIT_POS_W-1:0]     bit_reg, bit_next;
    logic [NUM_W-1:0]         res_alloc_reg, res_alloc_next;
    status_t                  res_status_reg, res_status_next;
    logic signed [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NUM_W-1:0]         cfg_reg;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic [NUM_W-1:0]         limit;
    logic [NUM_W-1:0]         in_num;
    logic [NUM_W-1:0]         in_idx;
    logic                     in_range;
    cmd_t                     in_cmd;

    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [WORD_W-1:0]        rd_data;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [WORD_W-1:0]        wr_data;
    hit_t                     hit;

    bffa_bitmap_mem #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bffa_first_zero #(
        .AW (AW)
    ) u_search (
        .word_data (rd_data),
        .word_idx  (word_reg),
        .limit     (limit_reg),
        .hit       (hit)
    );

    // Cap the limit at the bitmap size and decode the request beat
    always_comb
    begin
        limit    = (32'(cfg_reg) > 32'(MAX_ENTRIES)) ? NUM_W'(MAX_ENTRIES) : cfg_reg;
        in_cmd   = cmd_t'(s_tuser);
        in_num   = s_tdata[NUM_W-1:0];
        in_idx   = in_num - NUM_W'(1);
        in_range = (in_num != '0) && (in_num <= limit);
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Sequencer: scan or read, write the word back, hand out the beat; rejects skip ahead
    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        last_word_next  = last_word_reg;
        limit_next      = limit_reg;
        bit_next        = bit_reg;
        res_alloc_next  = res_alloc_reg;
        res_status_next = res_status_reg;
        cnt_next        = cnt_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        rd_en           = 1'b0;
        rd_addr         = word_reg;
        wr_en           = 1'b0;
        wr_addr         = word_reg;
        wr_data         = rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    limit_next      = limit;
                    last_word_next  = AW'((limit - NUM_W'(1)) >> BIT_POS_W);
                    res_alloc_next  = '0;
                    res_status_next = ST_OK;
                    if (in_cmd == CMD_ALLOC)
                    begin
                        if (limit == '0)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            word_next  = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else if (!in_range)
                    begin
                        res_status_next = ST_RANGE;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(in_idx >> BIT_POS_W);
                        word_next  = AW'(in_idx >> BIT_POS_W);
                        bit_next   = in_idx[BIT_POS_W-1:0];
                        state_next = S_FREE_MOD;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit.found)
                begin
                    wr_en          = 1'b1;
                    wr_data        = rd_data | (WORD_W'(1) << hit.pos);
                    res_alloc_next = NUM_W'({word_reg, hit.pos}) + NUM_W'(1);
                    cnt_next       = (cnt_reg == CNT_MIN) ? cnt_reg : cnt_reg - CNT_ONE;
                    state_next     = S_RESP;
                end
                else if (word_reg == last_word_reg)
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_RESP;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = word_reg + AW'(1);
                    word_next = word_reg + AW'(1);
                end
            end

            S_FREE_MOD:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data & ~(WORD_W'(1) << bit_reg);
                cnt_next   = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + CNT_ONE;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                // Load the output register once it is empty or being drained
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {OUT_PAD_W'(0), cnt_reg, res_status_reg, res_alloc_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            cfg_reg      <= LIMIT_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        last_word_reg  <= last_word_next;
        limit_reg      <= limit_next;
        bit_reg        <= bit_next;
        res_alloc_reg  <= res_alloc_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule

// ===== design/bffa_checker.sv =====
module bffa_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bffa_pkg::OUT_DATA_W-1:0] m_tdata
);
    import bffa_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Take one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // Only the three defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:14] == ST_OK) || (m_tdata[15:14] == ST_FULL)
                     || (m_tdata[15:14] == ST_RANGE))
        else $error("undefined status code");

    // A failed request never carries an entry number
    a_fail_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[15:14] != ST_OK) |-> (m_tdata[13:0] == '0))
        else $error("entry number on a failed request");

endmodule

bind bitmap_first_free_allocator_core bffa_checker u_bffa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_bitmap_first_free_allocator_core.sv =====
module tb_bitmap_first_free_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bffa_pkg::*;

    localparam int MAP_ENTRIES = MAX_ENTRIES_DEF;

    // One expected result beat
    typedef struct packed {
        logic [NUM_W-1:0]        number;
        status_t                 status;
        logic signed [CNT_W-1:0] count;
    } alloc_result_t;

    // Shadow bitmap and counter, plus the queue of results still owed by the block
    class allocator_scoreboard;
        bit               in_use [MAP_ENTRIES];
        int               lowest_maybe_free;    // every entry below this one is taken
        int               net_free;
        logic [NUM_W-1:0] limit_reg;
        alloc_result_t    owed_q [$];
        int               mismatches;

        function new();
            foreach (in_use[i])
                in_use[i] = 1'b0;
            lowest_maybe_free = 0;
            net_free          = 0;
            limit_reg         = LIMIT_RESET;
            mismatches        = 0;
        endfunction

        function void set_limit(logic [NUM_W-1:0] value);
            limit_reg = value;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void bump(int delta);
            net_free = net_free + delta;
            if (net_free > int'(CNT_MAX))
                net_free = int'(CNT_MAX);
            if (net_free < int'(CNT_MIN))
                net_free = int'(CNT_MIN);
        endfunction

        // Work out the result of one accepted request and queue it
        function void note_request(cmd_t cmd, logic [NUM_W-1:0] num);
            alloc_result_t r;
            int            span;
            int            idx;
            span     = (int'(limit_reg) > MAP_ENTRIES) ? MAP_ENTRIES : int'(limit_reg);
            r.number = '0;
            r.status = ST_OK;
            if (cmd == CMD_ALLOC)
            begin
                idx = lowest_maybe_free;
                while (idx < span && in_use[idx])
                    idx++;
                if (idx < span)
                begin
                    in_use[idx]       = 1'b1;
                    lowest_maybe_free = idx + 1;
                    bump(-1);
                    r.number = NUM_W'(idx + 1);
                end
                else
                begin
                    r.status = ST_FULL;
                    if (span > lowest_maybe_free)
                        lowest_maybe_free = span;
                end
            end
            else
            begin
                if (num == '0 || int'(num) > span)
                    r.status = ST_RANGE;
                else
                begin
                    in_use[int'(num) - 1] = 1'b0;
                    if (int'(num) - 1 < lowest_maybe_free)
                        lowest_maybe_free = int'(num) - 1;
                    bump(1);
                end
            end
            r.count = CNT_W'(net_free);
            owed_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // Compare one result beat field by field with the oldest expectation
        task check_result(logic [OUT_DATA_W-1:0] beat);
            alloc_result_t e;
            if (owed_q.size() == 0)
            begin
                report_mismatch($sformatf("result beat %h with nothing expected", beat));
                return;
            end
            e = owed_q.pop_front();
            if (beat[NUM_W-1:0] !== e.number)
                report_mismatch($sformatf("allocated_number %0d, expected %0d",
                                          beat[NUM_W-1:0], e.number));
            if (beat[NUM_W+STAT_W-1:NUM_W] !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          beat[NUM_W+STAT_W-1:NUM_W], e.status));
            if (beat[NUM_W+STAT_W+CNT_W-1:NUM_W+STAT_W] !== e.count)
                report_mismatch($sformatf("free_count %0d, expected %0d",
                                          $signed(beat[NUM_W+STAT_W+CNT_W-1:NUM_W+STAT_W]),
                                          e.count));
            if (beat[OUT_DATA_W-1:NUM_W+STAT_W+CNT_W] !== '0)
                report_mismatch($sformatf("pad bits set in result beat %h", beat));
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [NUM_W-1:0]      cfg_data  = '0;

    allocator_scoreboard sb = new();

    int burst_left   = 0;
    int hold_off_len = 0;

    bitmap_first_free_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check every result beat taken by the receiver
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Receiver: stretches of steady, patchy and heavy stalling, plus one long hold-off
    initial
    begin : rx_pattern
        int stretch_left;
        int rx_mode;
        stretch_left = 0;
        rx_mode      = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_len > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_off_len - 1) @(posedge clk);
                hold_off_len = 0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stretch_left = $urandom_range(8, 150);
                    rx_mode      = $urandom_range(0, 2);
                end
                stretch_left--;
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one request beat; hold it until taken, then maybe idle for a gap
    task automatic send_request(cmd_t cmd, logic [NUM_W-1:0] num);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-NUM_W){1'b0}}, num};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(cmd, num);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        else
            burst_left--;
    endtask

    // Stop offering and wait for every owed result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Write entries_in_use once the block is idle
    task automatic write_limit(logic [NUM_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_limit(value);
        cfg_valid <= 1'b0;
        cfg_data  <= NUM_W'($urandom);
    endtask

    // Mixed traffic under one limit: mostly in-range allocate/free, some noise
    task automatic run_phase(logic [NUM_W-1:0] value, int n_items);
        int               span;
        int               alloc_pct;
        int               pick;
        logic [NUM_W-1:0] num;
        write_limit(value);
        span      = (int'(value) > MAP_ENTRIES) ? MAP_ENTRIES : int'(value);
        alloc_pct = $urandom_range(35, 75);
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct)
                send_request(CMD_ALLOC, NUM_W'($urandom));
            else if (pick < 90 && span > 0)
                send_request(CMD_FREE, NUM_W'($urandom_range(1, span)));
            else
            begin
                case ($urandom_range(0, 3))
                    0:       num = '0;
                    1:       num = value + 1'b1;
                    2:       num = NUM_W'(span);
                    default: num = NUM_W'($urandom);
                endcase
                send_request(CMD_FREE, num);
            end
        end
    endtask

    initial
    begin : stimulus
        logic [NUM_W-1:0] phase_limits [12];
        phase_limits = '{14'd1, 14'd2, 14'd63, 14'd64, 14'd65, 14'd200,
                         14'd128, 14'd8192, 14'd16383, 14'd0, 14'd7, 14'd100};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Range rejects, free of a clear entry, lowest-first reuse at the reset limit
        send_request(CMD_FREE, 14'd0);
        send_request(CMD_FREE, 14'd8193);
        send_request(CMD_FREE, 14'h3FFF);
        send_request(CMD_FREE, 14'd1);
        send_request(CMD_ALLOC, 14'h3FFF);
        send_request(CMD_ALLOC, 14'd0);
        send_request(CMD_FREE, 14'd1);
        send_request(CMD_ALLOC, 14'h2AAA);

        // Fill a partial-word map under a long receiver hold-off, hit full, reuse the top entry
        write_limit(14'd70);
        hold_off_len = 300;
        repeat (72) send_request(CMD_ALLOC, NUM_W'($urandom));
        send_request(CMD_FREE, 14'd70);
        send_request(CMD_ALLOC, 14'h1555);
        send_request(CMD_ALLOC, 14'd0);

        // Limit above the map saturates; limit zero rejects everything
        write_limit(14'h3FFF);
        send_request(CMD_ALLOC, 14'd0);
        send_request(CMD_FREE, 14'd8192);
        send_request(CMD_FREE, 14'd8193);
        send_request(CMD_ALLOC, 14'd0);
        write_limit(14'd0);
        send_request(CMD_ALLOC, 14'd0);
        send_request(CMD_FREE, 14'd1);
        send_request(CMD_FREE, 14'd0);
        write_limit(14'd1);
        send_request(CMD_FREE, 14'd1);
        send_request(CMD_ALLOC, 14'd0);
        send_request(CMD_ALLOC, 14'd0);
        send_request(CMD_FREE, 14'd2);

        // Release the low entries, then pile up double frees
        write_limit(14'd8192);
        for (int i = 1; i <= 96; i++)
            send_request(CMD_FREE, NUM_W'(i));
        repeat (48) send_request(CMD_FREE, NUM_W'($urandom_range(1, 96)));

        // Random phases over several limits, raising and lowering it
        foreach (phase_limits[p])
        begin
            run_phase(phase_limits[p], $urandom_range(45, 65));
        end
        run_phase(NUM_W'($urandom_range(3, 300)), 80);
        run_phase(NUM_W'($urandom_range(1, 16383)), 60);

        drain();
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_bitmap_first_free_allocator_core: PASS");
        else
            $display("tb_bitmap_first_free_allocator_core: FAIL");
        $finish;
    end

    // Give up on a hang
    initial
    begin : watchdog
        #100ms;
        $display("tb_bitmap_first_free_allocator_core: FAIL");
        $finish;
    end

endmodule
